FILE: hdl/mcfb_pkg.sv
// shared types, constants and a function of the motor command frame builder
package mcfb_pkg;

    localparam int PAYLOAD_MAX = 12;
    localparam int FRAME_MAX   = 18;
    localparam int QUEUE_DEPTH = 2;
    localparam int IDX_W       = $clog2(FRAME_MAX);
    localparam int PIDX_W      = $clog2(PAYLOAD_MAX);
    localparam int PLEN_W      = $clog2(PAYLOAD_MAX + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] FRAME_HEADER   = 8'h3E;
    localparam logic [7:0] CMD_PID_READ   = 8'h30;
    localparam logic [7:0] CMD_PID_RAM    = 8'h31;
    localparam logic [7:0] CMD_PID_ROM    = 8'h32;
    localparam logic [7:0] CMD_TORQUE     = 8'hA1;
    localparam logic [7:0] CMD_ANGLE      = 8'hA3;
    localparam logic [7:0] CMD_ANGLE_SPD  = 8'hA4;
    localparam logic [7:0] CMD_READ_ANGLE = 8'h92;
    localparam logic [7:0] CMD_MOTOR_ON   = 8'h88;

    localparam logic signed [11:0] TORQUE_LIMIT = 12'sd2000;

    localparam logic [PLEN_W-1:0] PLEN_PID    = PLEN_W'(6);
    localparam logic [PLEN_W-1:0] PLEN_TORQUE = PLEN_W'(2);
    localparam logic [PLEN_W-1:0] PLEN_ANGLE  = PLEN_W'(8);
    localparam logic [PLEN_W-1:0] PLEN_SPD    = PLEN_W'(12);

    typedef enum logic [2:0] {
        ACT_PID_READ   = 3'd0,
        ACT_PID_RAM    = 3'd1,
        ACT_PID_ROM    = 3'd2,
        ACT_TORQUE     = 3'd3,
        ACT_ANGLE      = 3'd4,
        ACT_ANGLE_SPD  = 3'd5,
        ACT_READ_ANGLE = 3'd6,
        ACT_MOTOR_ON   = 3'd7
    } t_action;

    typedef struct packed {
        logic [7:0]                  cmd;
        logic [5:0]                  motor_addr;
        logic [PLEN_W-1:0]           plen;
        logic [PAYLOAD_MAX-1:0][7:0] payload;
    } t_frame;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } t_queue_status;

    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] idx;
    } t_back_status;

    function automatic logic [7:0] cmd_of(input t_action a);
        logic [7:0] c;
        case (a)
            ACT_PID_READ:   c = CMD_PID_READ;
            ACT_PID_RAM:    c = CMD_PID_RAM;
            ACT_PID_ROM:    c = CMD_PID_ROM;
            ACT_TORQUE:     c = CMD_TORQUE;
            ACT_ANGLE:      c = CMD_ANGLE;
            ACT_ANGLE_SPD:  c = CMD_ANGLE_SPD;
            ACT_READ_ANGLE: c = CMD_READ_ANGLE;
            ACT_MOTOR_ON:   c = CMD_MOTOR_ON;
            default:        c = CMD_PID_READ;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/mcfb_front.sv
// front end: classifies a command and builds its frame descriptor
module mcfb_front (
    input  logic [2:0]          i_action,
    input  logic [5:0]          i_motor_addr,
    input  logic [7:0]          i_angle_gain_p,
    input  logic [7:0]          i_angle_gain_i,
    input  logic [7:0]          i_speed_gain_p,
    input  logic [7:0]          i_speed_gain_i,
    input  logic [7:0]          i_current_gain_p,
    input  logic [7:0]          i_current_gain_i,
    input  logic signed [11:0]  i_torque_current,
    input  logic signed [63:0]  i_target_angle,
    input  logic [31:0]         i_speed_limit,
    output mcfb_pkg::t_frame    o_frame
);

    mcfb_pkg::t_action w_act;
    logic [63:0]        w_ang;
    logic [63:0]        w_scaled;
    logic signed [11:0] w_tq;
    logic [15:0]        w_tq16;

    assign w_act = mcfb_pkg::t_action'(i_action);
    assign w_ang = i_target_angle;
    // times 1000 as 1024 - 16 - 8
    assign w_scaled = (w_ang << 10) - (w_ang << 4) - (w_ang << 3);

    always_comb begin
        if (i_torque_current > mcfb_pkg::TORQUE_LIMIT) begin
            w_tq = mcfb_pkg::TORQUE_LIMIT;
        end else if (i_torque_current < -mcfb_pkg::TORQUE_LIMIT) begin
            w_tq = -mcfb_pkg::TORQUE_LIMIT;
        end else begin
            w_tq = i_torque_current;
        end
    end
    assign w_tq16 = {{4{w_tq[11]}}, w_tq};

    always_comb begin
        o_frame            = '0;
        o_frame.cmd        = mcfb_pkg::cmd_of(w_act);
        o_frame.motor_addr = i_motor_addr;
        case (w_act)
            mcfb_pkg::ACT_PID_RAM, mcfb_pkg::ACT_PID_ROM: begin
                o_frame.plen       = mcfb_pkg::PLEN_PID;
                o_frame.payload[0] = i_angle_gain_p;
                o_frame.payload[1] = i_angle_gain_i;
                o_frame.payload[2] = i_speed_gain_p;
                o_frame.payload[3] = i_speed_gain_i;
                o_frame.payload[4] = i_current_gain_p;
                o_frame.payload[5] = i_current_gain_i;
            end
            mcfb_pkg::ACT_TORQUE: begin
                o_frame.plen       = mcfb_pkg::PLEN_TORQUE;
                o_frame.payload[0] = w_tq16[7:0];
                o_frame.payload[1] = w_tq16[15:8];
            end
            mcfb_pkg::ACT_ANGLE: begin
                o_frame.plen = mcfb_pkg::PLEN_ANGLE;
                for (int k = 0; k < 8; k++) begin
                    o_frame.payload[k] = w_ang[8*k +: 8];
                end
            end
            mcfb_pkg::ACT_ANGLE_SPD: begin
                o_frame.plen = mcfb_pkg::PLEN_SPD;
                for (int k = 0; k < 8; k++) begin
                    o_frame.payload[k] = w_scaled[8*k +: 8];
                end
                for (int k = 0; k < 4; k++) begin
                    o_frame.payload[8+k] = i_speed_limit[8*k +: 8];
                end
            end
            default: begin
                o_frame.plen = '0;
            end
        endcase
    end

endmodule

FILE: hdl/mcfb_queue.sv
// short descriptor queue between front end and serializer
module mcfb_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  mcfb_pkg::t_frame          i_frame,
    output logic                      o_valid,
    input  logic                      i_ready,
    output mcfb_pkg::t_frame          o_frame,
    output mcfb_pkg::t_queue_status   o_status
);

    mcfb_pkg::t_frame                  r_mem [mcfb_pkg::QUEUE_DEPTH];
    logic [mcfb_pkg::QPTR_W-1:0]       r_wptr;
    logic [mcfb_pkg::QPTR_W-1:0]       r_rptr;
    logic [mcfb_pkg::QCNT_W-1:0]       r_count;
    logic                              w_push;
    logic                              w_pop;

    assign o_ready  = (r_count != mcfb_pkg::QCNT_W'(mcfb_pkg::QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_frame  = r_mem[r_rptr];
    assign w_push   = i_valid && o_ready;
    assign w_pop    = o_valid && i_ready;
    assign o_status.count = r_count;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == mcfb_pkg::QPTR_W'(mcfb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == mcfb_pkg::QPTR_W'(mcfb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/mcfb_back.sv
// back end: serializes one frame descriptor into bytes with checksums
module mcfb_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  mcfb_pkg::t_frame         i_frame,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [7:0]               o_frame_byte,
    output logic                     o_frame_end,
    output mcfb_pkg::t_back_status   o_status
);

    localparam logic [mcfb_pkg::IDX_W-1:0] POS_HEADER = mcfb_pkg::IDX_W'(0);
    localparam logic [mcfb_pkg::IDX_W-1:0] POS_CMD    = mcfb_pkg::IDX_W'(1);
    localparam logic [mcfb_pkg::IDX_W-1:0] POS_ID     = mcfb_pkg::IDX_W'(2);
    localparam logic [mcfb_pkg::IDX_W-1:0] POS_LEN    = mcfb_pkg::IDX_W'(3);
    localparam logic [mcfb_pkg::IDX_W-1:0] POS_HSUM   = mcfb_pkg::IDX_W'(4);
    localparam logic [mcfb_pkg::IDX_W-1:0] POS_DATA   = mcfb_pkg::IDX_W'(5);

    mcfb_pkg::t_frame                r_frame;
    logic                            r_busy;
    logic [mcfb_pkg::IDX_W-1:0]      r_idx;
    logic [7:0]                      r_hsum;
    logic [7:0]                      r_psum;
    logic                            r_ov;
    logic [7:0]                      r_byte;
    logic                            r_end;

    logic                            w_adv;
    logic                            w_emit;
    logic                            w_last;
    logic                            w_load;
    logic                            w_in_data;
    logic [mcfb_pkg::IDX_W-1:0]      w_pdiff;
    logic [mcfb_pkg::PIDX_W-1:0]     w_pidx;
    logic [mcfb_pkg::IDX_W-1:0]      w_sum_pos;
    logic [7:0]                      w_byte;
    logic [7:0]                      w_new_hsum;

    assign w_adv     = !r_ov || i_ready;
    assign w_emit    = w_adv && r_busy;
    assign w_sum_pos = mcfb_pkg::IDX_W'(r_frame.plen) + POS_DATA;
    assign w_last    = (r_frame.plen == '0) ? (r_idx == POS_HSUM) : (r_idx == w_sum_pos);
    assign w_in_data = (r_idx >= POS_DATA) && !w_last;
    assign w_pdiff   = r_idx - POS_DATA;
    assign w_pidx    = w_pdiff[mcfb_pkg::PIDX_W-1:0];
    assign w_load    = i_valid && (!r_busy || (w_emit && w_last));
    assign o_ready   = w_load;

    assign w_new_hsum = mcfb_pkg::FRAME_HEADER + i_frame.cmd + {2'b00, i_frame.motor_addr}
                      + 8'(i_frame.plen);

    always_comb begin
        case (r_idx)
            POS_HEADER: w_byte = mcfb_pkg::FRAME_HEADER;
            POS_CMD:    w_byte = r_frame.cmd;
            POS_ID:     w_byte = {2'b00, r_frame.motor_addr};
            POS_LEN:    w_byte = 8'(r_frame.plen);
            POS_HSUM:   w_byte = r_hsum;
            default: begin
                if (w_last) begin
                    w_byte = r_psum;
                end else if (w_pidx < mcfb_pkg::PIDX_W'(mcfb_pkg::PAYLOAD_MAX)) begin
                    w_byte = r_frame.payload[w_pidx];
                end else begin
                    w_byte = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_frame <= i_frame;
            r_hsum  <= w_new_hsum;
        end
        if (w_emit) begin
            r_byte <= w_byte;
            r_end  <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_psum <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (w_adv) begin
                r_ov <= r_busy;
            end
            if (w_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_psum <= '0;
            end else if (w_emit) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_idx  <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                    if (w_in_data) begin
                        r_psum <= r_psum + w_byte;
                    end
                end
            end
        end
    end

    assign o_valid         = r_ov;
    assign o_frame_byte    = r_byte;
    assign o_frame_end     = r_end;
    assign o_status.busy   = r_busy;
    assign o_status.idx    = r_idx;

endmodule

FILE: hdl/motor_command_frame_builder.sv
// top level of the motor command frame builder
// the command is written into the descriptor queue, then loaded into the serializer,
//   whose output register gives the first frame byte; one byte per cycle while i_ready is high
//   (5 to 18 bytes by frame length), set by the back end serializer; frames follow with no gap
// a two-entry descriptor queue lets the front accept while the back is sending
// reset: synchronous active low, clears queue, serializer and output valid
module motor_command_frame_builder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_action,
    input  logic [5:0]          i_motor_addr,
    input  logic [7:0]          i_angle_gain_p,
    input  logic [7:0]          i_angle_gain_i,
    input  logic [7:0]          i_speed_gain_p,
    input  logic [7:0]          i_speed_gain_i,
    input  logic [7:0]          i_current_gain_p,
    input  logic [7:0]          i_current_gain_i,
    input  logic signed [11:0]  i_torque_current,
    input  logic signed [63:0]  i_target_angle,
    input  logic [31:0]         i_speed_limit,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_frame_byte,
    output logic                o_frame_end
);

    mcfb_pkg::t_frame           w_front_frame;
    mcfb_pkg::t_frame           w_queue_frame;
    mcfb_pkg::t_queue_status    w_qstat;
    mcfb_pkg::t_back_status     w_bstat;
    logic                       w_q_valid;
    logic                       w_q_ready;

    mcfb_front u_front (
        .i_action         (i_action),
        .i_motor_addr     (i_motor_addr),
        .i_angle_gain_p   (i_angle_gain_p),
        .i_angle_gain_i   (i_angle_gain_i),
        .i_speed_gain_p   (i_speed_gain_p),
        .i_speed_gain_i   (i_speed_gain_i),
        .i_current_gain_p (i_current_gain_p),
        .i_current_gain_i (i_current_gain_i),
        .i_torque_current (i_torque_current),
        .i_target_angle   (i_target_angle),
        .i_speed_limit    (i_speed_limit),
        .o_frame          (w_front_frame)
    );

    mcfb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_frame  (w_front_frame),
        .o_valid  (w_q_valid),
        .i_ready  (w_q_ready),
        .o_frame  (w_queue_frame),
        .o_status (w_qstat)
    );

    mcfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .o_ready      (w_q_ready),
        .i_frame      (w_queue_frame),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end),
        .o_status     (w_bstat)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.count <= mcfb_pkg::QCNT_W'(mcfb_pkg::QUEUE_DEPTH))
        else $error("descriptor queue overflow");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.busy |-> (w_bstat.idx <= mcfb_pkg::IDX_W'(mcfb_pkg::FRAME_MAX - 1)))
        else $error("serializer index past frame end");

    a_header_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_frame_end) |=> !(o_valid && o_frame_end))
        else $error("frame end on the byte right after a frame end");

    a_full_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_qstat.count == mcfb_pkg::QCNT_W'(mcfb_pkg::QUEUE_DEPTH)) |-> !o_ready)
        else $error("ready while descriptor queue full");

endmodule
